// File: hw/rtl/mee_pkg.sv
package mee_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_CHECK = 2'd2;

  typedef enum logic [1:0] {
    MUL_REDUCE,
    MUL_ACC,
    MUL_SQUARE
  } mul_sel_t;

  typedef enum logic [1:0] {
    OUT_ACC,
    OUT_ZERO,
    OUT_FLAG
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     mul_step;
    logic     ebit_shift;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic small_mod;
    logic mul_last;
    logic ebit;
    logic ebits_zero;
  } status_t;

endpackage

// File: hw/rtl/mee_datapath.sv
module mee_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  mee_pkg::cmd_t                    cmd,
  input  logic [mee_pkg::DATA_WIDTH-1:0]   message,
  input  logic [mee_pkg::DATA_WIDTH-1:0]   modulus,
  input  logic [mee_pkg::DATA_WIDTH-1:0]   exponent,
  input  logic                             range_check,
  output mee_pkg::status_t                 status,
  output logic [mee_pkg::DATA_WIDTH-1:0]   result,
  output logic                             out_of_range
);

  localparam int DW = mee_pkg::DATA_WIDTH;
  localparam int CW = $clog2(DW);
  localparam int TW = DW + 2;

  logic [DW-1:0] op_a;
  logic [DW-1:0] op_b;
  logic [DW-1:0] r;
  logic [DW-1:0] base;
  logic [DW-1:0] acc;
  logic [DW-1:0] ebits;
  logic [CW-1:0] mcnt;
  mee_pkg::mul_sel_t sel;

  logic [DW-1:0] a_init;
  logic [DW-1:0] b_init;
  logic [TW-1:0] n_ext;
  logic [TW-1:0] t;
  logic [TW-1:0] d1;
  logic [TW-1:0] d2;
  logic [DW-1:0] r_next;
  logic          mul_last;

  // one interleaved step: r = (2r + a_msb * b) mod n, with t below 3n
  assign n_ext = {2'b00, modulus};
  assign t     = {1'b0, r, 1'b0} + (op_a[DW-1] ? {2'b00, op_b} : {TW{1'b0}});
  assign d1    = t - n_ext;
  assign d2    = t - {n_ext[TW-2:0], 1'b0};

  always_comb begin
    if (!d2[TW-1]) begin
      r_next = d2[DW-1:0];
    end else if (!d1[TW-1]) begin
      r_next = d1[DW-1:0];
    end else begin
      r_next = t[DW-1:0];
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      mee_pkg::MUL_REDUCE: begin
        a_init = message;
        b_init = DW'(1);
      end
      mee_pkg::MUL_ACC: begin
        a_init = acc;
        b_init = base;
      end
      mee_pkg::MUL_SQUARE: begin
        a_init = base;
        b_init = base;
      end
      default: begin
        a_init = base;
        b_init = base;
      end
    endcase
  end

  assign mul_last = (mcnt == CW'(DW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= '0;
    end else if (cmd.mul_start) begin
      mcnt <= '0;
    end else if (cmd.mul_step) begin
      mcnt <= mcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ebits <= exponent;
      acc   <= DW'(1);
    end
    if (cmd.mul_start) begin
      op_a <= a_init;
      op_b <= b_init;
      r    <= '0;
      sel  <= cmd.mul_sel;
    end else if (cmd.mul_step) begin
      op_a <= {op_a[DW-2:0], 1'b0};
      r    <= r_next;
      if (mul_last) begin
        case (sel)
          mee_pkg::MUL_ACC: acc  <= r_next;
          default:          base <= r_next;
        endcase
      end
    end
    if (cmd.ebit_shift) begin
      ebits <= ebits >> 1;
    end
    if (cmd.out_load) begin
      case (cmd.out_sel)
        mee_pkg::OUT_ACC: begin
          result       <= acc;
          out_of_range <= 1'b0;
        end
        mee_pkg::OUT_FLAG: begin
          result       <= '0;
          out_of_range <= 1'b1;
        end
        default: begin
          result       <= '0;
          out_of_range <= 1'b0;
        end
      endcase
    end
  end

  assign status.oor        = range_check && (message >= modulus);
  assign status.small_mod  = (modulus[DW-1:1] == '0);
  assign status.mul_last   = mul_last;
  assign status.ebit       = ebits[0];
  assign status.ebits_zero = (ebits == '0);

  a_step_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_step |=> (r < modulus))
    else $error("partial product not reduced below modulus");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_sel == mee_pkg::OUT_FLAG) |=> (out_of_range && result == '0))
    else $error("flagged request carries nonzero result");

endmodule

// File: hw/rtl/mee_controller.sv
module mee_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mee_pkg::status_t status,
  output mee_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_BIT,
    S_MUL_ACC,
    S_SQ_START,
    S_SQUARE,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.mul_start  = 1'b0;
    cmd.mul_sel    = mee_pkg::MUL_REDUCE;
    cmd.mul_step   = 1'b0;
    cmd.ebit_shift = 1'b0;
    cmd.out_load   = 1'b0;
    cmd.out_sel    = mee_pkg::OUT_ACC;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          if (status.oor) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = mee_pkg::OUT_FLAG;
            state_next   = S_OUT;
          end else if (status.small_mod) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = mee_pkg::OUT_ZERO;
            state_next   = S_OUT;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = mee_pkg::MUL_REDUCE;
            state_next    = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          state_next = S_BIT;
        end
      end
      S_BIT: begin
        if (status.ebits_zero) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = mee_pkg::OUT_ACC;
          state_next   = S_OUT;
        end else if (status.ebit) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mee_pkg::MUL_ACC;
          state_next    = S_MUL_ACC;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mee_pkg::MUL_SQUARE;
          state_next    = S_SQUARE;
        end
      end
      S_MUL_ACC: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          state_next = S_SQ_START;
        end
      end
      S_SQ_START: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = mee_pkg::MUL_SQUARE;
        state_next    = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          cmd.ebit_shift = 1'b1;
          state_next     = S_BIT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == S_IDLE);
      out_valid <= (state_next == S_OUT);
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while busy");

endmodule

// File: hw/rtl/modular_exponentiation_engine.sv
// Channel  | Handshake             | Payload
// input    | in_valid / in_ready   | message
// output   | out_valid / out_ready | result, out_of_range
// config   | cfg_write             | cfg_index, cfg_data
//
// One request at a time; result = message^exponent mod modulus.
// Each request first reduces the message, then scans the exponent from bit 0: a set bit
// multiplies the base into the accumulator, and every bit squares the base; scanning
// stops after the highest set bit. A single shared bit-serial modular multiplier does
// all of this, one bit per cycle. Flagged messages and modulus below 2 skip it.
// Reset is synchronous; registers return to modulus 2, exponent 1, range check on.
// A held result stalls the input side until it is taken.
module modular_exponentiation_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mee_pkg::DATA_WIDTH-1:0]      message,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mee_pkg::DATA_WIDTH-1:0]      result,
  output logic                                out_of_range,
  input  logic                                cfg_write,
  input  logic [mee_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mee_pkg::DATA_WIDTH-1:0]      cfg_data
);

  logic [mee_pkg::DATA_WIDTH-1:0] modulus;
  logic [mee_pkg::DATA_WIDTH-1:0] exponent;
  logic                           range_check;

  mee_pkg::cmd_t    cmd;
  mee_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= mee_pkg::DATA_WIDTH'(2);
      exponent    <= mee_pkg::DATA_WIDTH'(1);
      range_check <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        mee_pkg::REG_MODULUS:     modulus     <= cfg_data;
        mee_pkg::REG_EXPONENT:    exponent    <= cfg_data;
        mee_pkg::REG_RANGE_CHECK: range_check <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mee_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mee_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .message      (message),
    .modulus      (modulus),
    .exponent     (exponent),
    .range_check  (range_check),
    .status       (status),
    .result       (result),
    .out_of_range (out_of_range)
  );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mee_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic                  flag;
  } power_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [DATA_WIDTH-1:0] data;
    logic                  known;
    logic [DATA_WIDTH-1:0] value;
    logic                  flag;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [DATA_WIDTH-1:0]  message = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [DATA_WIDTH-1:0]  result;
  logic                   out_of_range;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_MODULUS;
  logic [DATA_WIDTH-1:0]  cfg_data = '0;

  logic [DATA_WIDTH-1:0] modulus_q = 32'd2;
  logic [DATA_WIDTH-1:0] exponent_q = 32'd1;
  logic                  range_check_q = 1'b1;
  power_t                pending_powers[$];
  int                    failures = 0;
  int                    in_calm = 0;
  int                    out_calm = 0;

  row_t directed_rows [26] = '{
    '{ROW_REQ, REG_MODULUS,     32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{ROW_REQ, REG_MODULUS,     32'h0000_0001, 1'b1, 32'h0000_0001, 1'b0},
    '{ROW_REQ, REG_MODULUS,     32'h0000_0002, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_REQ, REG_MODULUS,     32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_CFG, REG_MODULUS,     32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_CFG, REG_EXPONENT,    32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REQ, REG_MODULUS,     32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE, 1'b0},
    '{ROW_REQ, REG_MODULUS,     32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_REQ, REG_MODULUS,     32'h8000_0001, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_CFG, REG_RANGE_CHECK, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REQ, REG_MODULUS,     32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
    '{ROW_CFG, REG_EXPONENT,    32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REQ, REG_MODULUS,     32'h1234_5678, 1'b1, 32'h0000_0001, 1'b0},
    '{ROW_REQ, REG_MODULUS,     32'h0000_0000, 1'b1, 32'h0000_0001, 1'b0},
    '{ROW_CFG, REG_MODULUS,     32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REQ, REG_MODULUS,     32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
    '{ROW_CFG, REG_MODULUS,     32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REQ, REG_MODULUS,     32'h0000_0007, 1'b1, 32'h0000_0000, 1'b0},
    '{ROW_CFG, REG_RANGE_CHECK, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REQ, REG_MODULUS,     32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_CFG, REG_UNUSED,      32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
    '{ROW_CFG, REG_MODULUS,     32'd1000003,   1'b0, 32'h0000_0000, 1'b0},
    '{ROW_CFG, REG_EXPONENT,    32'd65537,     1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REQ, REG_MODULUS,     32'd999999,    1'b0, 32'h0000_0000, 1'b0},
    '{ROW_REQ, REG_MODULUS,     32'd1000003,   1'b1, 32'h0000_0000, 1'b1},
    '{ROW_REQ, REG_MODULUS,     32'd1000002,   1'b0, 32'h0000_0000, 1'b0}
  };

  modular_exponentiation_engine u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .message      (message),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result       (result),
    .out_of_range (out_of_range),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int draw_gap(inout int calm);
    int gap;
    if (calm > 0) begin
      calm = calm - 1;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 15) == 0) begin
        calm = $urandom_range(5, 25);
      end
    end
    return gap;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] power_mod(input logic [DATA_WIDTH-1:0] base,
                                                      input logic [DATA_WIDTH-1:0] expo,
                                                      input logic [DATA_WIDTH-1:0] n);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] wide_n;
    if (n < 2) begin
      return '0;
    end
    wide_n = {32'b0, n};
    acc = 64'd1;
    sq = {32'b0, base} % wide_n;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      if (expo[i]) begin
        acc = (acc * sq) % wide_n;
      end
      sq = (sq * sq) % wide_n;
    end
    return acc[DATA_WIDTH-1:0];
  endfunction

  function automatic power_t predict_power(input logic [DATA_WIDTH-1:0] msg);
    power_t p;
    if (range_check_q && msg >= modulus_q) begin
      p.value = '0;
      p.flag = 1'b1;
    end else begin
      p.value = power_mod(msg, exponent_q, modulus_q);
      p.flag = 1'b0;
    end
    return p;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_message();
    if (modulus_q > 1 && $urandom_range(0, 4) != 0) begin
      return $urandom % modulus_q;
    end
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return modulus_q + $urandom_range(0, 3);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
  endfunction

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [DATA_WIDTH-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_MODULUS: modulus_q = data;
      REG_EXPONENT: exponent_q = data;
      REG_RANGE_CHECK: range_check_q = data[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_powers.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic send_request(input logic [DATA_WIDTH-1:0] msg, input logic known,
                              input power_t typed);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    message = msg;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_powers.insert(pending_powers.size(), known ? typed : predict_power(msg));
    @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    power_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: result %h flag %b with no request outstanding",
                 $time, result, out_of_range);
        failures = failures + 1;
      end else begin
        want = pending_powers.pop_front();
        if (result !== want.value) begin
          $display("%0t: result expected %h got %h", $time, want.value, result);
          failures = failures + 1;
        end
        if (out_of_range !== want.flag) begin
          $display("%0t: out_of_range expected %b got %b", $time, want.flag, out_of_range);
          failures = failures + 1;
        end
      end
    end
  end

  initial begin : result_sink
    int gap;
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    #30ms;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [DATA_WIDTH-1:0] word;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain();
        write_register(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_request(directed_rows[i].data, directed_rows[i].known,
                     power_t'{directed_rows[i].value, directed_rows[i].flag});
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case ($urandom_range(0, 5))
        0: word = $urandom | 32'h8000_0000;
        1: word = $urandom_range(2, 255);
        2: word = 32'hFFFF_FFFF;
        3: word = $urandom_range(2, 65535);
        4: word = $urandom_range(0, 1);
        default: word = $urandom;
      endcase
      write_register(REG_MODULUS, word);
      case ($urandom_range(0, 4))
        0: word = $urandom;
        1: word = $urandom_range(0, 15);
        2: word = 32'd65537;
        3: word = 32'hFFFF_FFFF;
        default: word = $urandom_range(0, 255);
      endcase
      write_register(REG_EXPONENT, word);
      word = $urandom;
      word[0] = ($urandom_range(0, 3) != 0);
      write_register(REG_RANGE_CHECK, word);
      if ($urandom_range(0, 3) == 0) begin
        write_register(REG_UNUSED, $urandom);
      end
      for (int k = 0; k < 34; k++) begin
        send_request(pick_message(), 1'b0, '0);
      end
    end

    drain();
    repeat (2300) @(negedge clk);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
